>>> rtl/cpd_pkg.sv
// shared types and constants for the command packet deframer
// no dependencies; used by every other file of the block but cpd_ram

package cpd_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_STOP_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE  = 1'b1;

  localparam logic [BYTE_W-1:0] STOP_CODE_RST = 8'd191;
  localparam logic              RAW_MODE_RST  = 1'b0;

  typedef logic [BYTE_W-1:0] byte_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // input beat accepted
    logic prime;    // read packet entry 0
    logic advance;  // output beat taken, step to next entry
    logic raw_sel;  // present the raw byte
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic raw_mode;
    logic is_stop;
    logic at_last;
  } stat_t;

endpackage

>>> rtl/cpd_ifs.sv
// channel interfaces: input byte, packet output and register write
// depends on cpd_pkg

interface cpd_in_if;
  logic           valid;
  logic           ready;
  cpd_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cpd_out_if;
  logic           valid;
  logic           ready;
  cpd_pkg::byte_t packet_byte;
  logic           last_of_packet;
  logic           is_raw;

  modport source (output valid, output packet_byte, output last_of_packet, output is_raw,
                  input ready);
  modport sink   (input valid, input packet_byte, input last_of_packet, input is_raw,
                  output ready);
endinterface

interface cpd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cpd_pkg::CFG_IDX_W-1:0]   index;
  cpd_pkg::byte_t                  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/cpd_ram.sv
// generic single write port ram with registered read
// no dependencies

module cpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cpd_ctrl.sv
// controller state machine: sequences accept, packet drain and raw beats
// depends on cpd_pkg

module cpd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cpd_pkg::stat_t stat,
  output cpd_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_RAW   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_fire;
  logic       out_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DRAIN) || (state_r == S_RAW);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign cmd.load    = in_fire;
  assign cmd.prime   = (state_r == S_PRIME);
  assign cmd.advance = (state_r == S_DRAIN) && out_fire && !stat.at_last;
  assign cmd.raw_sel = (state_r == S_RAW);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (stat.raw_mode) begin
            state_nxt = S_RAW;
          end else if (stat.is_stop) begin
            state_nxt = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (out_fire && stat.at_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RAW: begin
        if (out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/cpd_dp.sv
// datapath: config registers, write position, packet store and output select
// depends on cpd_pkg and cpd_ram

module cpd_dp #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cpd_pkg::cmd_t                 cmd,
  output cpd_pkg::stat_t                stat,
  input  cpd_pkg::byte_t                rx_byte,
  input  logic                          cfg_we,
  input  logic [cpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  cpd_pkg::byte_t                cfg_data,
  output cpd_pkg::byte_t                packet_byte,
  output logic                          last_of_packet,
  output logic                          is_raw
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

  cpd_pkg::byte_t stop_code_r;
  logic           raw_mode_r;
  logic [AW-1:0]  pos_r;
  logic [AW-1:0]  pos_nxt;
  logic [AW-1:0]  last_r;
  logic [AW-1:0]  idx_r;
  cpd_pkg::byte_t raw_byte_r;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic           is_start;
  cpd_pkg::byte_t ram_dout;

  assign is_start = rx_byte > stop_code_r;
  assign wr_addr  = is_start ? '0 : pos_r;
  assign wr_en    = cmd.load && !raw_mode_r;

  assign stat.raw_mode = raw_mode_r;
  assign stat.is_stop  = (rx_byte == stop_code_r);
  assign stat.at_last  = (idx_r == last_r);

  always_comb begin
    if (stat.is_stop || (wr_addr == TOP_ADDR)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = wr_addr + AW'(1);
    end
  end

  always_comb begin
    if (cmd.prime) begin
      rd_addr = '0;
    end else if (cmd.advance) begin
      rd_addr = idx_r + AW'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  cpd_ram #(
    .WIDTH (cpd_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (rx_byte),
    .raddr (rd_addr),
    .rdata (ram_dout)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_code_r <= cpd_pkg::STOP_CODE_RST;
      raw_mode_r  <= cpd_pkg::RAW_MODE_RST;
      pos_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cpd_pkg::CFG_STOP_CODE: stop_code_r <= cfg_data;
          cpd_pkg::CFG_RAW_MODE:  raw_mode_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (wr_en) begin
        pos_r <= pos_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_r <= wr_addr;
    end
    if (cmd.load) begin
      raw_byte_r <= rx_byte;
    end
    if (cmd.prime || cmd.advance) begin
      idx_r <= rd_addr;
    end
  end

  assign packet_byte    = cmd.raw_sel ? raw_byte_r : ram_dout;
  assign last_of_packet = cmd.raw_sel || stat.at_last;
  assign is_raw         = cmd.raw_sel;

endmodule

>>> rtl/command_packet_deframer.sv
// top level of the command packet deframer: controller, datapath and channel ports
// depends on cpd_pkg, cpd_ifs, cpd_ctrl and cpd_dp
//
// channel  dir  payload                                  beat when
// in_ch    in   rx_byte                                  valid && ready
// out_ch   out  packet_byte, last_of_packet, is_raw      valid && ready
// cfg_ch   in   index, data                              valid && ready (ready always high)
//
// a byte that does not end a packet is stored and the block stays ready for the next byte
// a stop byte is accepted, then the store is read (prime state), then the packet drains one byte per output beat
// a raw byte is accepted, then presented as a single output beat
// output stalls hold the current beat; input is not taken while a packet drains
// rst_n is synchronous: stop code 191, framing mode, write position 0

module command_packet_deframer #(
  parameter int PACKET_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  cpd_in_if.sink      in_ch,
  cpd_out_if.source   out_ch,
  cpd_cfg_if.sink     cfg_ch
);

  cpd_pkg::cmd_t  cmd;
  cpd_pkg::stat_t stat;

  assign cfg_ch.ready = 1'b1;

  cpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpd_dp #(
    .DEPTH (PACKET_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .rx_byte        (in_ch.rx_byte),
    .cfg_we         (cfg_ch.valid && cfg_ch.ready),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .packet_byte    (out_ch.packet_byte),
    .last_of_packet (out_ch.last_of_packet),
    .is_raw         (out_ch.is_raw)
  );

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while output beat pending");

  a_stop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !stat.raw_mode && stat.is_stop)
      |=> !out_ch.valid ##1 out_ch.valid)
    else $error("stop byte did not start a packet drain");

  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_packet) |=> out_ch.valid)
    else $error("packet drain stopped before last beat");
`endif

endmodule

>>> tb/tb_command_packet_deframer.sv
`timescale 1ns / 100ps
// self-checking testbench for command_packet_deframer: framed, overflowing and raw byte traffic
// predicts every packet beat in a scoreboard class; depends on cpd_pkg, cpd_ifs and the rtl

module tb_command_packet_deframer;

  localparam int PERIOD      = 12;
  localparam int DEPTH       = 16;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS       = 310;

  typedef struct packed {
    cpd_pkg::byte_t data;
    logic           last;
    logic           raw;
  } beat_t;

  class packet_tracker;
    cpd_pkg::byte_t stop_code;
    logic           raw_mode;
    int unsigned    wr_pos;
    cpd_pkg::byte_t frame_buf[DEPTH];
    beat_t          pending[$];
    int             errors;

    function new();
      stop_code = cpd_pkg::STOP_CODE_RST;
      raw_mode  = cpd_pkg::RAW_MODE_RST;
      wr_pos    = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [cpd_pkg::CFG_IDX_W-1:0] idx, cpd_pkg::byte_t val);
      if (idx == cpd_pkg::CFG_STOP_CODE) stop_code = val;
      else raw_mode = val[0];
    endfunction

    function void take_byte(cpd_pkg::byte_t b);
      beat_t e;
      if (raw_mode) begin
        e = '{data: b, last: 1'b1, raw: 1'b1};
        pending.push_back(e);
        return;
      end
      if (b > stop_code) wr_pos = 0;
      frame_buf[wr_pos] = b;
      wr_pos++;
      if (b == stop_code) begin
        for (int unsigned i = 0; i < wr_pos; i++) begin
          e = '{data: frame_buf[i], last: (i + 1 == wr_pos), raw: 1'b0};
          pending.push_back(e);
        end
        wr_pos = 0;
      end else if (wr_pos >= DEPTH) begin
        wr_pos = 0;
      end
    endfunction

    function void match_beat(cpd_pkg::byte_t d, logic l, logic r);
      beat_t e;
      if (pending.size() == 0) begin
        $display("%0t: expected no beat, actual data=%h last=%b raw=%b", $time, d, l, r);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.data !== d) begin
        $display("%0t: packet_byte expected %h actual %h", $time, e.data, d);
        errors++;
      end
      if (e.last !== l) begin
        $display("%0t: last_of_packet expected %b actual %b", $time, e.last, l);
        errors++;
      end
      if (e.raw !== r) begin
        $display("%0t: is_raw expected %b actual %b", $time, e.raw, r);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  cpd_in_if  in_if();
  cpd_out_if out_if();
  cpd_cfg_if cfg_if();

  command_packet_deframer #(.PACKET_DEPTH(DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  packet_tracker sb;
  logic calm       = 1'b0;
  int   hold_asks  = 0;
  int   items_sent = 0;

  always #(PERIOD / 2) clk = ~clk;

  task automatic send_byte(input cpd_pkg::byte_t b);
    if (!calm && $urandom_range(99, 0) < 13) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.take_byte(b);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [cpd_pkg::CFG_IDX_W-1:0] idx,
                           input cpd_pkg::byte_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_payload(input int len);
    cpd_pkg::byte_t stop;
    stop = sb.stop_code;
    if (stop != 8'd255 && $urandom_range(9, 0) != 0)
      send_byte(cpd_pkg::byte_t'($urandom_range(255, stop + 1)));
    if (stop != 8'd0)
      for (int i = 0; i < len; i++)
        send_byte(cpd_pkg::byte_t'($urandom_range(stop - 1, 0)));
  endtask

  task automatic send_frame();
    int len;
    len = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 14) : $urandom_range(8, 0);
    send_payload(len);
    send_byte(sb.stop_code);
  endtask

  // receiving side
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        sb.match_beat(out_if.packet_byte, out_if.last_of_packet, out_if.is_raw);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= calm || ($urandom_range(99, 0) >= 13);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_command_packet_deframer: FAIL");
    $finish;
  end

  initial begin
    int rand_base;
    int phase_base;
    int ph;
    int r;
    sb = new();
    in_if.valid   <= 1'b0;
    in_if.rx_byte <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= cpd_pkg::CFG_STOP_CODE;
    cfg_if.data   <= '0;
    rst_n         <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone stop, full frame at the byte extremes, stop without start
    send_byte(8'd191);
    send_byte(8'd255); send_byte(8'd0); send_byte(8'd190); send_byte(8'd191);
    send_byte(8'h55); send_byte(8'haa); send_byte(8'd191);
    // partial packet survives a trip through raw mode
    send_byte(8'd220); send_byte(8'h11);
    wait_idle();
    write_cfg(cpd_pkg::CFG_RAW_MODE, 8'd1);
    send_byte(8'd0); send_byte(8'd255); send_byte(8'd191);
    wait_idle();
    write_cfg(cpd_pkg::CFG_RAW_MODE, 8'd0);
    send_byte(8'd191);
    // stop code 255: no start bytes
    wait_idle();
    write_cfg(cpd_pkg::CFG_STOP_CODE, 8'd255);
    send_byte(8'd254); send_byte(8'd0); send_byte(8'd255);
    // stop code 0
    wait_idle();
    write_cfg(cpd_pkg::CFG_STOP_CODE, 8'd0);
    send_byte(8'd0); send_byte(8'd1); send_byte(8'd0);

    rand_base = items_sent;
    ph = 0;
    while (items_sent - rand_base < ITEMS) begin
      wait_idle();
      calm = (ph % 7 == 2);
      case (ph % 7)
        0: write_cfg(cpd_pkg::CFG_STOP_CODE, 8'd191);
        1: write_cfg(cpd_pkg::CFG_STOP_CODE, 8'd254);
        3: write_cfg(cpd_pkg::CFG_STOP_CODE, 8'd0);
        4: write_cfg(cpd_pkg::CFG_STOP_CODE, 8'd255);
        default: write_cfg(cpd_pkg::CFG_STOP_CODE, cpd_pkg::byte_t'($urandom_range(253, 1)));
      endcase
      write_cfg(cpd_pkg::CFG_RAW_MODE, (ph % 7 == 5) ? 8'd1 : 8'd0);
      phase_base = items_sent;
      if (ph % 7 == 0) begin
        // receiver holds off while a full packet drains
        hold_asks++;
        send_payload(14);
        send_byte(sb.stop_code);
      end
      while (items_sent - phase_base < ((ph % 7 == 5) ? 20 : 40) &&
             items_sent - rand_base < ITEMS) begin
        r = $urandom_range(99, 0);
        if (sb.raw_mode) send_byte(cpd_pkg::byte_t'($urandom_range(255, 0)));
        else if (r < 75) send_frame();
        else if (r < 87) send_payload($urandom_range(6, 0));
        else repeat ($urandom_range(4, 1)) send_byte(cpd_pkg::byte_t'($urandom_range(255, 0)));
      end
      ph++;
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_command_packet_deframer: PASS");
    else
      $display("tb_command_packet_deframer: FAIL");
    $finish;
  end

endmodule

>>> command_packet_deframer.f
rtl/cpd_pkg.sv
rtl/cpd_ifs.sv
rtl/cpd_ram.sv
rtl/cpd_ctrl.sv
rtl/cpd_dp.sv
rtl/command_packet_deframer.sv
tb/tb_command_packet_deframer.sv
